[hdl/ssa_pkg.sv]
// Shared types and constants for the sized slot allocator.
package ssa_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 64;
  localparam int unsigned NUM_CLASSES   = 5;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned CLS_W         = 3;
  localparam int unsigned SLOT_W        = 7;
  localparam int unsigned ST_W          = 3;
  localparam int unsigned IN_W          = 16;
  localparam int unsigned OUT_W         = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_OCCUPY = 2'd2,
    CMD_FREE   = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_CLASS = 3'd1,
    ST_FULL      = 3'd2,
    ST_NONE_FREE = 3'd3,
    ST_NOT_AVAIL = 3'd4,
    ST_NOT_OCC   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIND
  } state_e;

endpackage

[hdl/sized_slot_allocator.sv]
// Top level of the sized slot allocator: command sequencer and output register.
// Sequence: add, occupy and free read the class memory, then execute in S_EXEC; find
//   does the memory read, then the two-stage free-slot search in S_FIND.
// Throughput: one word in flight, set by the read-modify-write of the class memory;
//   the next is accepted once the previous result loads, which waits while output stalls.
// Reset: all classes empty and nothing occupied, via per-class valid bits at once.
module sized_slot_allocator #(
  parameter int unsigned MAX_SLOTS = ssa_pkg::MAX_SLOTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  // [1:0] command, [4:2] size_class, [11:5] slot_number
  input  logic [ssa_pkg::IN_W-1:0]  s_tdata_i,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  // [0] ok, [3:1] status, [10:4] slot_result
  output logic [ssa_pkg::OUT_W-1:0] m_tdata_o
);
  import ssa_pkg::*;

  state_e state_q, state_d;

  cmd_e              cmd_q;
  logic [CLS_W-1:0]  cls_q;
  logic              bad_q;
  logic [SLOT_W-1:0] n_q;

  logic [CMD_W-1:0]  in_cmd;
  logic [CLS_W-1:0]  in_cls;
  logic [SLOT_W-1:0] in_n;
  logic              in_bad;
  logic              accept;

  logic [SLOT_W-1:0]    rd_cnt;
  logic [MAX_SLOTS-1:0] rd_map;
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_cnt;
  logic [MAX_SLOTS-1:0] wr_map;

  logic [MAX_SLOTS-1:0] exist_mask, free_vec, add_sel, n_sel;
  logic                 add_full, n_exists, n_busy;
  logic                 ffs_found;
  logic [SLOT_W-1:0]    ffs_slot;

  logic              go, load_out;
  logic              res_ok;
  status_e           res_st;
  logic [SLOT_W-1:0] res_slot;

  logic              out_vld_q;
  logic              out_ok_q;
  status_e           out_st_q;
  logic [SLOT_W-1:0] out_slot_q;

  assign in_cmd = s_tdata_i[CMD_W-1:0];
  assign in_cls = s_tdata_i[CMD_W +: CLS_W];
  assign in_n   = s_tdata_i[CMD_W+CLS_W +: SLOT_W];
  assign in_bad = in_cls >= CLS_W'(NUM_CLASSES);
  assign accept = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(in_cmd);
      cls_q <= in_cls;
      bad_q <= in_bad;
      n_q   <= in_n;
    end
  end

  ssa_store #(.MAX_SLOTS(MAX_SLOTS)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && !in_bad),
    .rd_addr_i (in_cls),
    .rd_cnt_o  (rd_cnt),
    .rd_map_o  (rd_map),
    .wr_en_i   (wr_en),
    .wr_addr_i (cls_q),
    .wr_cnt_i  (wr_cnt),
    .wr_map_i  (wr_map)
  );

  // slot n lives in bit n-1; slots 1..count exist
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      exist_mask[i] = SLOT_W'(i) < rd_cnt;
    end
  end

  assign free_vec = ~rd_map & exist_mask;
  assign add_full = rd_cnt >= SLOT_W'(MAX_SLOTS);
  assign add_sel  = MAX_SLOTS'(1) << rd_cnt;
  assign n_exists = (n_q != '0) && (n_q <= rd_cnt);
  assign n_sel    = MAX_SLOTS'(1) << (n_q - SLOT_W'(1));
  assign n_busy   = |(rd_map & n_sel);

  ssa_ffs #(.MAX_SLOTS(MAX_SLOTS)) u_ffs (
    .clk_i   (clk_i),
    .free_i  (free_vec),
    .found_o (ffs_found),
    .slot_o  (ffs_slot)
  );

  assign go = !out_vld_q || m_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q == CMD_FIND && !bad_q) begin
          state_d = S_FIND;
        end else if (go) begin
          state_d = S_IDLE;
        end
      end
      S_FIND: begin
        if (go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready_o = 1'b0;
    load_out   = 1'b0;
    wr_en      = 1'b0;
    wr_cnt     = rd_cnt;
    wr_map     = rd_map;
    res_ok     = 1'b0;
    res_st     = ST_OK;
    res_slot   = '0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
      end
      S_EXEC: begin
        if (bad_q) begin
          load_out = go;
          res_st   = ST_BAD_CLASS;
        end else begin
          unique case (cmd_q)
            CMD_ADD: begin
              load_out = go;
              if (add_full) begin
                res_st = ST_FULL;
              end else begin
                wr_en    = go;
                wr_cnt   = rd_cnt + SLOT_W'(1);
                wr_map   = rd_map & ~add_sel;
                res_ok   = 1'b1;
                res_slot = rd_cnt + SLOT_W'(1);
              end
            end
            CMD_OCCUPY: begin
              load_out = go;
              if (n_exists && !n_busy) begin
                wr_en  = go;
                wr_map = rd_map | n_sel;
                res_ok = 1'b1;
              end else begin
                res_st = ST_NOT_AVAIL;
              end
            end
            CMD_FREE: begin
              load_out = go;
              if (n_exists && n_busy) begin
                wr_en  = go;
                wr_map = rd_map & ~n_sel;
                res_ok = 1'b1;
              end else begin
                res_st = ST_NOT_OCC;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIND: begin
        load_out = go;
        if (ffs_found) begin
          res_ok   = 1'b1;
          res_slot = ffs_slot;
        end else begin
          res_st = ST_NONE_FREE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_ok_q   <= res_ok;
      out_st_q   <= res_st;
      out_slot_q <= res_slot;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {(OUT_W - 1 - ST_W - SLOT_W)'(0), out_slot_q, out_st_q, out_ok_q};

`ifndef SYNTHESIS
  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("word accepted while previous still in work");

  // ok flag agrees with status
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[0] == (m_tdata_o[3:1] == ST_OK)))
    else $error("ok flag and status disagree");

  // failed commands report slot zero
  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tdata_o[0] |-> (m_tdata_o[10:4] == '0))
    else $error("failed command reports a slot");

  // memory is written only while a word is executing
  a_wr_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_EXEC) && !bad_q)
    else $error("class memory written outside execution");
`endif

endmodule

[hdl/ssa_store.sv]
// Class state memory: slot count and occupancy map per class, registered read.
module ssa_store #(
  parameter int unsigned MAX_SLOTS = ssa_pkg::MAX_SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [ssa_pkg::CLS_W-1:0]  rd_addr_i,
  output logic [ssa_pkg::SLOT_W-1:0] rd_cnt_o,
  output logic [MAX_SLOTS-1:0]       rd_map_o,
  input  logic                       wr_en_i,
  input  logic [ssa_pkg::CLS_W-1:0]  wr_addr_i,
  input  logic [ssa_pkg::SLOT_W-1:0] wr_cnt_i,
  input  logic [MAX_SLOTS-1:0]       wr_map_i
);
  import ssa_pkg::*;

  logic [SLOT_W-1:0]    cnt_mem_q [NUM_CLASSES];
  logic [MAX_SLOTS-1:0] map_mem_q [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] vld_q;
  logic [SLOT_W-1:0]    rd_cnt_q;
  logic [MAX_SLOTS-1:0] rd_map_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      cnt_mem_q[wr_addr_i] <= wr_cnt_i;
      map_mem_q[wr_addr_i] <= wr_map_i;
    end
    if (rd_en_i) begin
      rd_cnt_q <= cnt_mem_q[rd_addr_i];
      rd_map_q <= map_mem_q[rd_addr_i];
    end
  end

  // an entry never written reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_cnt_o = rd_vld_q ? rd_cnt_q : '0;
  assign rd_map_o = rd_vld_q ? rd_map_q : '0;

endmodule

[hdl/ssa_ffs.sv]
// Two-stage lowest-free-slot search: registered per-byte scan, then group select.
module ssa_ffs #(
  parameter int unsigned MAX_SLOTS = ssa_pkg::MAX_SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic [MAX_SLOTS-1:0]       free_i,
  output logic                       found_o,
  output logic [ssa_pkg::SLOT_W-1:0] slot_o
);
  import ssa_pkg::*;

  localparam int unsigned NGRP  = (MAX_SLOTS + 7) / 8;
  localparam int unsigned PAD_W = NGRP * 8;

  logic [PAD_W-1:0] pad;
  logic [NGRP-1:0]  grp_any_d, grp_any_q;
  logic [2:0]       grp_lo_d [NGRP];
  logic [2:0]       grp_lo_q [NGRP];

  assign pad = PAD_W'(free_i);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g] = |pad[g*8 +: 8];
      grp_lo_d[g]  = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (pad[g*8 + b]) begin
          grp_lo_d[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    for (int g = 0; g < NGRP; g++) begin
      grp_lo_q[g] <= grp_lo_d[g];
    end
  end

  always_comb begin
    slot_o = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        slot_o = SLOT_W'(g * 8) + SLOT_W'(grp_lo_q[g]) + SLOT_W'(1);
      end
    end
  end

  assign found_o = |grp_any_q;

endmodule

[tb/sized_slot_allocator_tb.sv]
// Self-checking testbench for the sized slot allocator.
`timescale 1ns / 100ps

module sized_slot_allocator_tb;
  import ssa_pkg::*;

  localparam int GEN_VIEW = 0;  // state seen by the stimulus generator
  localparam int CHK_VIEW = 1;  // state advanced by accepted words only

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] cls;
    logic [6:0] slot;
  } alloc_req_t;

  typedef struct packed {
    logic       ok;
    status_e    status;
    logic [6:0] slot;
  } alloc_result_t;

  logic              clk_i;
  logic              rst_ni     = 1'b0;
  logic              s_tvalid_i = 1'b0;
  logic              s_tready_o;
  // [1:0] command, [4:2] size_class, [11:5] slot_number
  logic [IN_W-1:0]   s_tdata_i  = '0;
  logic              m_tvalid_o;
  logic              m_tready_i = 1'b0;
  // [0] ok, [3:1] status, [10:4] slot_result
  logic [OUT_W-1:0]  m_tdata_o;

  logic              rx_hold = 1'b0;
  logic              in_fire, out_fire;

  alloc_req_t        pending_cmds[$];
  alloc_result_t     expected_results[$];

  int                slot_cnt [2][NUM_CLASSES];
  logic [63:0]       occ_map  [2][NUM_CLASSES];

  int                total_items    = 0;
  int                items_accepted = 0;
  int                results_seen   = 0;
  int                mismatches     = 0;
  int                in_wait        = 0;
  int                out_wait       = 0;
  bit                in_burst       = 1'b0;
  bit                out_burst      = 1'b0;

  sized_slot_allocator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Executes one command against one copy of the allocator state.
  function automatic alloc_result_t apply_command(int view, alloc_req_t r);
    alloc_result_t res;
    int c;
    int s;
    int cnt;
    res.ok     = 1'b0;
    res.status = ST_OK;
    res.slot   = '0;
    c = r.cls;
    s = r.slot;
    if (c >= NUM_CLASSES) begin
      res.status = ST_BAD_CLASS;
      return res;
    end
    cnt = slot_cnt[view][c];
    case (r.cmd)
      CMD_ADD: begin
        if (cnt >= MAX_SLOTS_DEF) begin
          res.status = ST_FULL;
        end else begin
          slot_cnt[view][c] = cnt + 1;
          occ_map[view][c][cnt] = 1'b0;
          res.ok   = 1'b1;
          res.slot = 7'(cnt + 1);
        end
      end
      CMD_FIND: begin
        res.status = ST_NONE_FREE;
        for (int n = 1; n <= cnt && !res.ok; n++) begin
          if (!occ_map[view][c][n-1]) begin
            res.ok     = 1'b1;
            res.status = ST_OK;
            res.slot   = 7'(n);
          end
        end
      end
      CMD_OCCUPY: begin
        if (s >= 1 && s <= cnt && !occ_map[view][c][s-1]) begin
          occ_map[view][c][s-1] = 1'b1;
          res.ok = 1'b1;
        end else begin
          res.status = ST_NOT_AVAIL;
        end
      end
      CMD_FREE: begin
        if (s >= 1 && s <= cnt && occ_map[view][c][s-1]) begin
          occ_map[view][c][s-1] = 1'b0;
          res.ok = 1'b1;
        end else begin
          res.status = ST_NOT_OCC;
        end
      end
    endcase
    return res;
  endfunction

  // Random existing slot that is occupied (or free); a random slot from 1 to 64 if there is none.
  function automatic logic [6:0] pick_slot(int cls, bit want_occ);
    int hits[$];
    for (int n = 1; n <= slot_cnt[GEN_VIEW][cls]; n++)
      if (occ_map[GEN_VIEW][cls][n-1] == want_occ) hits.insert(hits.size(), n);
    if (hits.size() == 0) return 7'($urandom_range(1, 64));
    return 7'(hits[$urandom_range(0, hits.size() - 1)]);
  endfunction

  function automatic void queue_cmd(cmd_e cmd, int cls, int slot);
    alloc_req_t r;
    r.cmd  = cmd;
    r.cls  = 3'(cls);
    r.slot = 7'(slot);
    pending_cmds.insert(pending_cmds.size(), r);
    void'(apply_command(GEN_VIEW, r));
    total_items++;
  endfunction

  function automatic int draw_gap(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 9);
  endfunction

  // Sender: one word per handshake, random gap after each accepted word.
  always @(negedge clk_i) begin
    alloc_req_t r;
    if (rst_ni) begin
      if (in_fire) begin
        if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
        in_wait = draw_gap(in_burst);
      end
      if (s_tvalid_i && !in_fire) begin
        // hold the word until it is taken
      end else if (in_wait > 0) begin
        s_tvalid_i <= 1'b0;
        in_wait--;
      end else if (pending_cmds.size() > 0) begin
        r = pending_cmds.pop_front();
        s_tdata_i  <= {4'b0, r.slot, r.cls, r.cmd};
        s_tvalid_i <= 1'b1;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall after each result word, plus the long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
        out_wait = draw_gap(out_burst);
      end
      if (rx_hold) begin
        m_tready_i <= 1'b0;
      end else if (out_wait > 0) begin
        m_tready_i <= 1'b0;
        out_wait--;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // Stall the output for long stretches while words keep coming in.
  initial begin
    wait (items_accepted >= 500);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(negedge clk_i);
    rx_hold <= 1'b0;
    wait (items_accepted >= 1200);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (250) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_req_t    got_req;
    alloc_result_t want;
    if (!rst_ni) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= s_tvalid_i && s_tready_o;
      out_fire <= m_tvalid_o && m_tready_i;
      if (m_tvalid_o && m_tready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result word %h with none expected", $time, m_tdata_o);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata_o[0] !== want.ok) begin
            mismatches++;
            $display("%0t: ok expected %0d actual %0d", $time, want.ok, m_tdata_o[0]);
          end
          if (m_tdata_o[3:1] !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_tdata_o[3:1]);
          end
          if (m_tdata_o[10:4] !== want.slot) begin
            mismatches++;
            $display("%0t: slot expected %0d actual %0d", $time, want.slot,
                     m_tdata_o[10:4]);
          end
        end
      end
      if (s_tvalid_i && s_tready_o) begin
        got_req.cmd  = cmd_e'(s_tdata_i[1:0]);
        got_req.cls  = s_tdata_i[4:2];
        got_req.slot = s_tdata_i[11:5];
        expected_results.insert(expected_results.size(),
                                apply_command(CHK_VIEW, got_req));
        items_accepted++;
      end
    end
  end

  initial begin
    int  focus;
    int  roll;
    int  cls;
    int  slot;
    bit  fill_mode;
    cmd_e cmd;

    for (int v = 0; v < 2; v++)
      for (int c = 0; c < NUM_CLASSES; c++) begin
        slot_cnt[v][c] = 0;
        occ_map[v][c]  = '0;
      end

    // Directed: empty class, bad class codes, slot edges, numeric ordering.
    queue_cmd(CMD_FIND,   0, 0);
    queue_cmd(CMD_OCCUPY, 0, 1);
    queue_cmd(CMD_FREE,   0, 1);
    for (int c = 0; c < NUM_CLASSES; c++) queue_cmd(CMD_ADD, c, 0);
    queue_cmd(CMD_ADD,    5, 0);
    queue_cmd(CMD_FIND,   6, 0);
    queue_cmd(CMD_OCCUPY, 7, 1);
    queue_cmd(CMD_FREE,   7, 127);
    queue_cmd(CMD_OCCUPY, 0, 0);
    queue_cmd(CMD_OCCUPY, 0, 127);
    queue_cmd(CMD_OCCUPY, 0, 1);
    queue_cmd(CMD_OCCUPY, 0, 1);
    queue_cmd(CMD_FIND,   0, 0);
    queue_cmd(CMD_ADD,    0, 127);
    queue_cmd(CMD_FIND,   0, 0);
    queue_cmd(CMD_FREE,   0, 1);
    queue_cmd(CMD_FIND,   0, 0);
    queue_cmd(CMD_FREE,   0, 1);
    queue_cmd(CMD_FREE,   0, 2);
    queue_cmd(CMD_OCCUPY, 1, 64);
    queue_cmd(CMD_FREE,   4, 0);

    // Random: segments focused on one class, each with a fill or drain mix chosen at random.
    focus     = 0;
    fill_mode = 1'b1;
    for (int k = 0; k < 1625; k++) begin
      if (k % 250 == 0) begin
        focus     = $urandom_range(0, NUM_CLASSES - 1);
        fill_mode = ($urandom_range(0, 2) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        queue_cmd(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 7),
                  $urandom_range(0, 127));
      end else begin
        cls  = ($urandom_range(0, 3) != 0) ? focus : $urandom_range(0, NUM_CLASSES - 1);
        roll = $urandom_range(0, 99);
        if (fill_mode)
          cmd = roll < 40 ? CMD_ADD : roll < 75 ? CMD_OCCUPY : roll < 90 ? CMD_FIND : CMD_FREE;
        else
          cmd = roll < 15 ? CMD_ADD : roll < 40 ? CMD_OCCUPY : roll < 60 ? CMD_FIND : CMD_FREE;
        if ((cmd == CMD_OCCUPY || cmd == CMD_FREE) && $urandom_range(0, 9) != 0)
          slot = pick_slot(cls, cmd == CMD_FREE);
        else
          slot = $urandom_range(0, 127);
        queue_cmd(cmd, cls, slot);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (items_accepted == total_items);
    wait (results_seen == total_items);
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
